// ===== sv/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants of the 1-Wire bus master
// Phase codes, command codes, register indexes, counter width and the
// item, result and configuration records used between the modules.
// ----------------------------------------------------------------------------
package owbm_pkg;

	// tick counter width and its saturation value
	localparam int COUNT_BITS = 12;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	// width that holds a count plus one and any 12-bit register
	localparam int CMP_W = ((COUNT_BITS > 12) ? COUNT_BITS : 12) + 1;

	// command codes on func
	localparam logic [2:0] FN_TICK   = 3'd0;
	localparam logic [2:0] FN_RESET  = 3'd1;
	localparam logic [2:0] FN_TOUCH  = 3'd2;
	localparam logic [2:0] FN_READ   = 3'd3;
	localparam logic [2:0] FN_WRITE  = 3'd4;
	localparam logic [2:0] FN_STRONG = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_RESET_LOW    = 3'd0;
	localparam logic [2:0] REG_PRESENCE_WIN = 3'd1;
	localparam logic [2:0] REG_SHORT_WIN    = 3'd2;
	localparam logic [2:0] REG_RESET_SETTLE = 3'd3;
	localparam logic [2:0] REG_SLOT         = 3'd4;
	localparam logic [2:0] REG_RECOVERY     = 3'd5;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_SLOT_LOW,
		PH_SLOT_REL
	} phase_t;

	typedef struct packed {
		logic [11:0] reset_low_ticks;
		logic [11:0] presence_window_ticks;
		logic [11:0] short_window_ticks;
		logic [7:0]  reset_settle_ticks;
		logic [11:0] slot_ticks;
		logic [7:0]  recovery_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] data_byte;
		logic       line_sense;
	} item_t;

	typedef struct packed {
		logic       drive_low;
		logic       drive_high;
		logic       busy_res;
		logic       done_res;
		logic       status_ok;
		logic [7:0] read_data;
		logic       rejected;
	} result_t;

	// true on the last tick of an interval of len ticks, or at saturation
	function automatic logic at_last(logic [COUNT_BITS-1:0] tc, logic [11:0] len);
		logic [CMP_W-1:0] a;
		logic [CMP_W-1:0] b;
		a = CMP_W'(tc) + CMP_W'(1);
		b = CMP_W'(len);
		return (a >= b) || (tc == CMAX);
	endfunction

endpackage

// ===== sv/one_wire_bus_master_core.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_core: 1-Wire bus master, one line
// Tick-driven master: each request is one microsecond tick carrying the
// sampled line level and optionally a command; each gives one result.
// ----------------------------------------------------------------------------
//
// channel  | dir | fields (lowest bit first)
// ---------+-----+------------------------------------------------------------
// s_axis   | in  | tdata: data_byte[7:0], line_sense[8]; tuser: func[2:0]
// m_axis   | out | tdata: drive_low, drive_high, busy_res, done_res,
//          |     |        status_ok, read_data[12:5], rejected[13]
// cfg      | in  | cfg_we, cfg_addr (register index), cfg_wdata[11:0]
//
// One request per cycle sustained while m_tready holds; each result is offered
// on m_axis once its request has passed the input register and then the sequencer
// step into the result register.
// The sequencer state advances only when a request moves into the result
// register, so stalls on m_tready freeze the bus timing without loss.
// arst_n clears the pipeline and returns the timing registers to defaults.
//
module one_wire_bus_master_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // data_byte[7:0], line_sense[8], zero[15:9]
	input  logic [2:0]  s_tuser,   // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // drive_low, drive_high, busy_res, done_res,
	                               // status_ok, read_data[12:5], rejected[13]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [11:0] cfg_wdata
);

	owbm_pkg::cfg_t    cfg;
	owbm_pkg::item_t   item_s1;
	logic              valid_s1;
	owbm_pkg::result_t step_res;
	owbm_pkg::result_t res_q;
	logic              res_valid_q;
	logic              advance;

	owbm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// pipeline handshake
	assign advance  = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func       <= s_tuser;
			item_s1.data_byte  <= s_tdata[7:0];
			item_s1.line_sense <= s_tdata[8];
		end
	end

	owbm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (step_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= 1'b1;
		else if (m_tready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= step_res;
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {2'b00, res_q.rejected, res_q.read_data, res_q.status_ok,
		res_q.done_res, res_q.busy_res, res_q.drive_high, res_q.drive_low};

endmodule

// ===== sv/owbm_cfg.sv =====
// ----------------------------------------------------------------------------
// owbm_cfg: timing register file
// Six write-only timing registers, loaded from the plain write port.
// ----------------------------------------------------------------------------
module owbm_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_addr,
	input  logic [11:0]       cfg_wdata,
	output owbm_pkg::cfg_t    cfg
);

	owbm_pkg::cfg_t regs_q;

	// register writes; unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.reset_low_ticks       <= 12'd480;
			regs_q.presence_window_ticks <= 12'd120;
			regs_q.short_window_ticks    <= 12'd500;
			regs_q.reset_settle_ticks    <= 8'd1;
			regs_q.slot_ticks            <= 12'd60;
			regs_q.recovery_ticks        <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_addr)
				owbm_pkg::REG_RESET_LOW:    regs_q.reset_low_ticks <= cfg_wdata;
				owbm_pkg::REG_PRESENCE_WIN: regs_q.presence_window_ticks <= cfg_wdata;
				owbm_pkg::REG_SHORT_WIN:    regs_q.short_window_ticks <= cfg_wdata;
				owbm_pkg::REG_RESET_SETTLE: regs_q.reset_settle_ticks <= cfg_wdata[7:0];
				owbm_pkg::REG_SLOT:         regs_q.slot_ticks <= cfg_wdata;
				owbm_pkg::REG_RECOVERY:     regs_q.recovery_ticks <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

// ===== sv/owbm_engine.sv =====
// ----------------------------------------------------------------------------
// owbm_engine: bus master sequencer
// Holds the operation state and steps it once per tick request, producing
// the line drive, status and completion result for that tick.
// ----------------------------------------------------------------------------
module owbm_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  owbm_pkg::item_t   item,
	input  owbm_pkg::cfg_t    cfg,
	output owbm_pkg::result_t res
);

	localparam int CB = owbm_pkg::COUNT_BITS;

	owbm_pkg::phase_t phase_q, phase_d;
	logic [2:0]    op_q, op_d;
	logic [CB-1:0] tick_q, tick_d;
	logic [2:0]    bit_q, bit_d;
	logic [7:0]    shift_q, shift_d;
	logic          ok_q, ok_d;
	logic          seen_q, seen_d;
	logic          hold_q, hold_d;

	// state registers, stepped on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owbm_pkg::PH_IDLE;
			op_q    <= '0;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			ok_q    <= 1'b1;
			seen_q  <= 1'b0;
			hold_q  <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			op_q    <= op_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			ok_q    <= ok_d;
			seen_q  <= seen_d;
			hold_q  <= hold_d;
		end
	end

	// one tick of the sequencer
	always_comb begin
		logic        fin;
		logic        low;
		logic        slot;
		logic        cb;
		logic        wr;
		logic [7:0]  rec;
		logic [11:0] slen;
		logic [11:0] len;
		logic        is_cmd;

		phase_d = phase_q;
		op_d    = op_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		ok_d    = ok_q;
		seen_d  = seen_q;
		hold_d  = hold_q;
		res     = '0;
		fin     = 1'b0;
		low     = 1'b0;
		slot    = 1'b0;
		len     = '0;

		// command start, or reject while busy
		is_cmd = (item.func >= owbm_pkg::FN_RESET) && (item.func <= owbm_pkg::FN_STRONG);
		if (is_cmd) begin
			if (phase_q != owbm_pkg::PH_IDLE) begin
				res.rejected = 1'b1;
			end else begin
				hold_d  = 1'b0;
				op_d    = item.func;
				tick_d  = '0;
				bit_d   = '0;
				seen_d  = 1'b0;
				shift_d = '0;
				ok_d    = 1'b1;
				if (item.func == owbm_pkg::FN_RESET) begin
					phase_d = owbm_pkg::PH_RST_LOW;
				end else begin
					phase_d = owbm_pkg::PH_SLOT_LOW;
					if (item.func == owbm_pkg::FN_TOUCH) begin
						shift_d = {7'd0, item.data_byte[0]};
						ok_d    = 1'b0;
					end else if (item.func == owbm_pkg::FN_WRITE ||
						item.func == owbm_pkg::FN_STRONG) begin
						shift_d = item.data_byte;
						ok_d    = item.line_sense;
					end
				end
			end
		end

		wr   = (op_d == owbm_pkg::FN_WRITE) || (op_d == owbm_pkg::FN_STRONG);
		cb   = (op_d == owbm_pkg::FN_READ) || shift_d[0];
		rec  = wr ? cfg.recovery_ticks : 8'd0;
		slen = (cfg.slot_ticks == 12'd0) ? 12'd1 : cfg.slot_ticks;

		case (phase_d)
			owbm_pkg::PH_RST_LOW: begin
				res.drive_low = 1'b1;
				if (owbm_pkg::at_last(tick_d, cfg.reset_low_ticks)) begin
					phase_d = owbm_pkg::PH_RST_WAIT;
					tick_d  = '0;
				end else if (tick_d != owbm_pkg::CMAX) begin
					tick_d = tick_d + CB'(1);
				end
			end
			owbm_pkg::PH_RST_WAIT: begin
				if (!seen_d) begin
					if ((owbm_pkg::CMP_W'(tick_d) > owbm_pkg::CMP_W'(cfg.reset_settle_ticks))
						&& !item.line_sense) begin
						seen_d = 1'b1;
					end else if ((owbm_pkg::CMP_W'(tick_d) >=
						owbm_pkg::CMP_W'(cfg.presence_window_ticks)) ||
						(tick_d == owbm_pkg::CMAX)) begin
						ok_d = 1'b0;
						fin  = 1'b1;
					end
				end else if (item.line_sense) begin
					ok_d = 1'b1;
					fin  = 1'b1;
				end else if ((owbm_pkg::CMP_W'(tick_d) >=
					owbm_pkg::CMP_W'(cfg.short_window_ticks)) ||
					(tick_d == owbm_pkg::CMAX)) begin
					ok_d = 1'b0;
					fin  = 1'b1;
				end
				if (!fin && tick_d != owbm_pkg::CMAX)
					tick_d = tick_d + CB'(1);
			end
			owbm_pkg::PH_SLOT_LOW: begin
				slot = 1'b1;
				low  = 1'b1;
				len  = cb ? 12'd1 : slen;
				if (owbm_pkg::at_last(tick_d, len)) begin
					if (cb || rec != 8'd0) begin
						phase_d = owbm_pkg::PH_SLOT_REL;
						tick_d  = '0;
					end else begin
						// end of slot without a released part
						if (wr)
							shift_d = shift_d >> 1;
						if (op_d == owbm_pkg::FN_TOUCH || bit_d == 3'd7) begin
							fin = 1'b1;
						end else begin
							bit_d   = bit_d + 3'd1;
							phase_d = owbm_pkg::PH_SLOT_LOW;
							tick_d  = '0;
						end
					end
				end else if (tick_d != owbm_pkg::CMAX) begin
					tick_d = tick_d + CB'(1);
				end
			end
			owbm_pkg::PH_SLOT_REL: begin
				slot = 1'b1;
				// sample on the first released tick
				if (cb && tick_d == '0) begin
					if (op_d == owbm_pkg::FN_TOUCH)
						ok_d = item.line_sense;
					else if (op_d == owbm_pkg::FN_READ)
						shift_d = {item.line_sense, shift_d[7:1]};
					else if (!item.line_sense)
						ok_d = 1'b0;
				end
				len = cb ? slen : {4'd0, rec};
				if (owbm_pkg::at_last(tick_d, len)) begin
					if (wr)
						shift_d = shift_d >> 1;
					if (op_d == owbm_pkg::FN_TOUCH || bit_d == 3'd7) begin
						fin = 1'b1;
					end else begin
						bit_d   = bit_d + 3'd1;
						phase_d = owbm_pkg::PH_SLOT_LOW;
						tick_d  = '0;
					end
				end else if (tick_d != owbm_pkg::CMAX) begin
					tick_d = tick_d + CB'(1);
				end
			end
			default: begin
				phase_d = owbm_pkg::PH_IDLE;
			end
		endcase

		// line drive during slots
		if (slot) begin
			res.drive_low = low;
			if (op_d == owbm_pkg::FN_STRONG)
				res.drive_high = !low;
		end

		// completion
		if (fin) begin
			res.done_res  = 1'b1;
			phase_d       = owbm_pkg::PH_IDLE;
			res.status_ok = ok_d;
			if (op_d == owbm_pkg::FN_TOUCH) begin
				res.read_data = {7'd0, ok_d};
			end else if (op_d == owbm_pkg::FN_READ) begin
				res.status_ok = 1'b1;
				res.read_data = shift_d;
			end else if (op_d == owbm_pkg::FN_STRONG) begin
				hold_d = 1'b1;
			end
		end else if (phase_d == owbm_pkg::PH_IDLE) begin
			res.drive_high = hold_d;
		end

		res.busy_res = (phase_d != owbm_pkg::PH_IDLE);
	end

endmodule
